@@ hw/rtl/bptm_pkg.sv @@
package bptm_pkg;

    // field widths of the two channels
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 24;
    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_MATCH  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // original byte value that matches any byte
    localparam logic [BYTE_W-1:0] ANY_BYTE = 8'hFF;

    // commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                issue;
        logic                rd_last;
        logic                wr_hit;
        logic                wr_app;
        logic                move;
        logic                clr;
        logic                res_hit;
        logic                res_code_en;
        logic [STATUS_W-1:0] res_code;
        logic                out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            slot_oor;
        logic            scan_done;
        logic            hit_match;
        logic            hit_addr;
        logic            out_free;
    } stat_t;

endpackage

@@ hw/rtl/bptm_req_if.sv @@
interface bptm_req_if;
    logic                          valid;
    logic                          ready;
    logic [bptm_pkg::OP_W-1:0]     op;
    logic [bptm_pkg::ADDR_W-1:0]   addr;
    logic [bptm_pkg::BYTE_W-1:0]   cmp_byte;
    logic [bptm_pkg::BYTE_W-1:0]   repl_byte;
    logic                          enable_flag;
    logic [bptm_pkg::SLOT_W-1:0]   slot;

    modport source (
        output valid, op, addr, cmp_byte, repl_byte, enable_flag, slot,
        input  ready
    );
    modport sink (
        input  valid, op, addr, cmp_byte, repl_byte, enable_flag, slot,
        output ready
    );
endinterface

@@ hw/rtl/bptm_rsp_if.sv @@
interface bptm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bptm_pkg::STATUS_W-1:0]   status;
    logic [bptm_pkg::BYTE_W-1:0]     patched_byte;
    logic [bptm_pkg::COUNT_W-1:0]    entry_count;

    modport source (
        output valid, status, patched_byte, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, patched_byte, entry_count,
        output ready
    );
endinterface

@@ hw/rtl/bptm_ctrl.sv @@
module bptm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  bptm_pkg::stat_t  stat,
    output bptm_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    // sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.op)
                    bptm_pkg::OP_MATCH:
                    begin
                        cmd.issue  = 1'b1;
                        state_next = S_SCAN;
                    end
                    bptm_pkg::OP_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_code_en = 1'b1;
                            cmd.res_code    = bptm_pkg::ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.issue  = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    bptm_pkg::OP_REMOVE:
                    begin
                        if (stat.slot_oor)
                        begin
                            cmd.res_code_en = 1'b1;
                            cmd.res_code    = bptm_pkg::ST_RANGE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = S_MOVE;
                        end
                    end
                    default:
                    begin
                        cmd.clr         = 1'b1;
                        cmd.res_code_en = 1'b1;
                        cmd.res_code    = bptm_pkg::ST_OK;
                        state_next      = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.op == bptm_pkg::OP_MATCH)
                begin
                    if (stat.hit_match)
                    begin
                        cmd.res_hit = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else if (stat.scan_done)
                    begin
                        cmd.res_code_en = 1'b1;
                        cmd.res_code    = bptm_pkg::ST_MISS;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cmd.issue = 1'b1;
                    end
                end
                else
                begin
                    if (stat.hit_addr)
                    begin
                        cmd.wr_hit      = 1'b1;
                        cmd.res_code_en = 1'b1;
                        cmd.res_code    = bptm_pkg::ST_OK;
                        state_next      = S_FINISH;
                    end
                    else if (stat.scan_done)
                    begin
                        cmd.wr_app      = 1'b1;
                        cmd.res_code_en = 1'b1;
                        cmd.res_code    = bptm_pkg::ST_OK;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cmd.issue = 1'b1;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move        = 1'b1;
                cmd.res_code_en = 1'b1;
                cmd.res_code    = bptm_pkg::ST_OK;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/bptm_dp.sv @@
module bptm_dp #(
    parameter int ENTRIES   = 64,
    parameter int ADDR_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bptm_pkg::cmd_t                  cmd,
    output bptm_pkg::stat_t                 stat,
    input  logic [bptm_pkg::OP_W-1:0]       in_op,
    input  logic [bptm_pkg::ADDR_W-1:0]     in_addr,
    input  logic [bptm_pkg::BYTE_W-1:0]     in_cmp_byte,
    input  logic [bptm_pkg::BYTE_W-1:0]     in_repl_byte,
    input  logic                            in_enable_flag,
    input  logic [bptm_pkg::SLOT_W-1:0]     in_slot,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bptm_pkg::STATUS_W-1:0]   out_status,
    output logic [bptm_pkg::BYTE_W-1:0]     out_patched_byte,
    output logic [bptm_pkg::COUNT_W-1:0]    out_entry_count
);

    localparam int AW    = (ADDR_BITS < bptm_pkg::ADDR_W) ? ADDR_BITS : bptm_pkg::ADDR_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = bptm_pkg::SLOT_W + 1;

    typedef struct packed {
        logic [AW-1:0]                 addr;
        logic [bptm_pkg::BYTE_W-1:0]   orig;
        logic [bptm_pkg::BYTE_W-1:0]   repl;
        logic                          en;
    } entry_t;

    entry_t mem [ENTRIES];

    // request registers
    logic [bptm_pkg::OP_W-1:0]     op_reg;
    logic [AW-1:0]                 addr_reg;
    logic [bptm_pkg::BYTE_W-1:0]   ob_reg;
    logic [bptm_pkg::BYTE_W-1:0]   nb_reg;
    logic                          en_reg;
    logic [bptm_pkg::SLOT_W-1:0]   slot_reg;

    // table and scan state
    logic [CNT_W-1:0] live_reg;
    logic [CNT_W-1:0] live_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    entry_t           rd_data_reg;

    // result registers
    logic [bptm_pkg::STATUS_W-1:0] res_status_reg;
    logic [bptm_pkg::BYTE_W-1:0]   res_byte_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [bptm_pkg::STATUS_W-1:0] out_status_reg;
    logic [bptm_pkg::BYTE_W-1:0]   out_byte_reg;
    logic [CNT_W-1:0]              out_count_reg;

    logic [CNT_W-1:0]   live_m1;
    logic [IDX_W-1:0]   last_idx;
    logic               issue_ok;
    logic               addr_eq;
    logic               orig_ok;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    entry_t             req_entry;
    logic [CNT_W+6:0]   count_ext;

    assign live_m1  = live_reg - CNT_W'(1);
    assign last_idx = live_m1[IDX_W-1:0];
    assign issue_ok = cmd.issue && (idx_reg != live_reg);

    // compare of the entry read last cycle
    assign addr_eq = (rd_data_reg.addr == addr_reg);
    assign orig_ok = (rd_data_reg.orig == bptm_pkg::ANY_BYTE) || (rd_data_reg.orig == ob_reg);

    always_comb
    begin
        stat           = '0;
        stat.op        = op_reg;
        stat.full      = (live_reg == CNT_W'(ENTRIES));
        stat.slot_oor  = ({1'b0, slot_reg} >= CMP_W'(live_reg));
        stat.scan_done = (live_reg == '0) || (rd_vld_reg && (rd_idx_reg == live_m1));
        stat.hit_match = rd_vld_reg && rd_data_reg.en && addr_eq && orig_ok;
        stat.hit_addr  = rd_vld_reg && addr_eq;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // table write port select
    always_comb
    begin
        req_entry.addr = addr_reg;
        req_entry.orig = ob_reg;
        req_entry.repl = nb_reg;
        req_entry.en   = en_reg;
        wr_en          = cmd.wr_hit || cmd.wr_app || cmd.move;
        wr_addr        = live_reg[IDX_W-1:0];
        wr_data        = req_entry;
        if (cmd.wr_hit)
        begin
            wr_addr = rd_idx_reg[IDX_W-1:0];
        end
        else if (cmd.move)
        begin
            wr_addr = slot_reg[IDX_W-1:0];
            wr_data = rd_data_reg;
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (issue_ok)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
        else if (cmd.rd_last)
        begin
            rd_data_reg <= mem[last_idx];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // next values of control state
    always_comb
    begin
        live_next = live_reg;
        if (cmd.clr)
        begin
            live_next = '0;
        end
        else if (cmd.wr_app)
        begin
            live_next = live_reg + CNT_W'(1);
        end
        else if (cmd.move)
        begin
            live_next = live_m1;
        end

        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (issue_ok)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end

        rd_vld_next = issue_ok;

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture, scan index and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            addr_reg <= in_addr[AW-1:0];
            ob_reg   <= in_cmp_byte;
            nb_reg   <= in_repl_byte;
            en_reg   <= in_enable_flag;
            slot_reg <= in_slot;
        end
        if (issue_ok)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (cmd.res_hit)
        begin
            res_status_reg <= bptm_pkg::ST_OK;
            res_byte_reg   <= rd_data_reg.repl;
        end
        else if (cmd.res_code_en)
        begin
            res_status_reg <= cmd.res_code;
            res_byte_reg   <= '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_byte_reg   <= res_byte_reg;
            out_count_reg  <= live_reg;
        end
    end

    assign count_ext        = {7'b0, out_count_reg};
    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_patched_byte = out_byte_reg;
    assign out_entry_count  = count_ext[bptm_pkg::COUNT_W-1:0];

endmodule

@@ hw/rtl/byte_patch_table_matcher.sv @@
// Byte patch table matcher. Keeps a packed table of up to ENTRIES patches
// (address, expected original byte with 0xFF as wildcard, replacement byte,
// enable) in one single-port-read memory and answers one result beat per
// request beat: match, add or replace, remove by slot, clear. Match and add
// walk the live entries one per cycle through the memory read port; match
// stops at the first enabled hit and add at the first address hit. Remove
// reads the last live entry and moves it into the removed slot, while
// clear, a refused add and an out-of-range remove need no table read. Only
// slots below the live count are ever read, so reset and clear take effect
// at once with no sweep of the memory. A finished result waits in an output
// register; while the previous result is still held there the request
// stalls in its last cycle, and the next request is accepted once the new
// result has been loaded.
module byte_patch_table_matcher #(
    parameter int ENTRIES   = 64,
    parameter int ADDR_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    bptm_req_if.sink   req,
    bptm_rsp_if.source rsp
);

    bptm_pkg::cmd_t  cmd;
    bptm_pkg::stat_t stat;

    // sequencer
    bptm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, compare and result registers
    bptm_dp #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_op            (req.op),
        .in_addr          (req.addr),
        .in_cmp_byte      (req.cmp_byte),
        .in_repl_byte     (req.repl_byte),
        .in_enable_flag   (req.enable_flag),
        .in_slot          (req.slot),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_status       (rsp.status),
        .out_patched_byte (rsp.patched_byte),
        .out_entry_count  (rsp.entry_count)
    );

endmodule
